// ===== hdl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;

    localparam int OPC_W  = 2;
    localparam int ADR_W  = 32;
    localparam int OUT_W  = 2;
    localparam int CNT_W  = 32;
    localparam int PADR_W = 4;
    localparam int PDAT_W = 32;

    localparam int SIB_W  = 3;
    localparam int WAYS_W = 4;
    localparam int OFS_W  = 5;

    localparam logic [OPC_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPC_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OPC_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OPC_W-1:0] OP_FETCH  = 2'd3;

    localparam logic [OUT_W-1:0] OUTCOME_MISS  = 2'd0;
    localparam logic [OUT_W-1:0] OUTCOME_HIT   = 2'd1;
    localparam logic [OUT_W-1:0] OUTCOME_EVICT = 2'd2;

    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_WAYS        = 2'd1;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

    typedef struct packed {
        logic clr;
        logic take;
        logic rd;
        logic cmp_wr;
        logic scan_init;
        logic scan_step;
        logic vic_wr;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic req_fetch;
        logic hit_any;
        logic inv_any;
        logic scan_none;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/slc_req_if.sv =====
// ----------------------------------------------------------------------------
// slc_req_if
// Access channel: opcode and byte address with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface slc_req_if;
    import slc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [ADR_W-1:0] address;

    modport source (output valid, output opcode, output address, input ready);
    modport sink   (input valid, input opcode, input address, output ready);
endinterface

`default_nettype wire

// ===== hdl/slc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// slc_rsp_if
// Result channel: outcome, extra hit and running totals with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface slc_rsp_if;
    import slc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] outcome;
    logic             extra_hit;
    logic [CNT_W-1:0] total_hits;
    logic [CNT_W-1:0] total_misses;
    logic [CNT_W-1:0] total_evictions;

    modport source (output valid, output outcome, output extra_hit, output total_hits,
                    output total_misses, output total_evictions, input ready);
    modport sink   (input valid, input outcome, input extra_hit, input total_hits,
                    input total_misses, input total_evictions, output ready);
endinterface

`default_nettype wire

// ===== hdl/slc_dp.sv =====
// ----------------------------------------------------------------------------
// slc_dp
// Datapath: set row memory, tag compare, LRU scan, totals and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_dp #(
    parameter int MAX_SET_BITS = slc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = slc_pkg::DEF_MAX_WAYS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [slc_pkg::SIB_W-1:0]  i_cfg_set_bits,
    input  wire logic [slc_pkg::WAYS_W-1:0] i_cfg_ways,
    input  wire logic [slc_pkg::OFS_W-1:0]  i_cfg_offset,
    input  wire slc_pkg::t_cmd              i_cmd,
    output slc_pkg::t_sts                   o_sts,
    input  wire logic [slc_pkg::OPC_W-1:0]  i_opcode,
    input  wire logic [slc_pkg::ADR_W-1:0]  i_address,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic [slc_pkg::OUT_W-1:0]       o_outcome,
    output logic                            o_extra_hit,
    output logic [slc_pkg::CNT_W-1:0]       o_total_hits,
    output logic [slc_pkg::CNT_W-1:0]       o_total_misses,
    output logic [slc_pkg::CNT_W-1:0]       o_total_evictions
);
    import slc_pkg::*;

    localparam int SETS = 1 << MAX_SET_BITS;
    localparam int SIW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    // set row memory
    logic [31:0]         r_mem_clk   [SETS];
    logic [MAX_WAYS-1:0] r_mem_valid [SETS];
    logic [31:0]         r_mem_tag   [SETS][MAX_WAYS];
    logic [31:0]         r_mem_stamp [SETS][MAX_WAYS];

    logic [31:0]         r_q_clk;
    logic [MAX_WAYS-1:0] r_q_valid;
    logic [31:0]         r_q_tag   [MAX_WAYS];
    logic [31:0]         r_q_stamp [MAX_WAYS];

    logic [SIW-1:0]   r_clr_cnt;
    logic [SIW-1:0]   r_set;
    logic [ADR_W-1:0] r_block;
    logic             r_extra;

    logic [WW-1:0] r_way;
    logic [WW-1:0] r_vic;
    logic [31:0]   r_vic_stamp;

    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] r_evicts;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_outcome;
    logic             r_out_extra;

    logic [ADR_W-1:0]    n_block;
    logic [SIW-1:0]      n_set_mask;
    logic [MAX_WAYS-1:0] n_active;
    logic [MAX_WAYS-1:0] n_hit;
    logic [MAX_WAYS-1:0] n_inv;
    logic [WW-1:0]       n_hit_way;
    logic [WW-1:0]       n_inv_way;
    logic [WW-1:0]       n_wsel;
    logic                n_wr;
    logic                n_load;
    logic [SIW-1:0]      n_waddr;
    logic [31:0]         n_wd_clk;
    logic [MAX_WAYS-1:0] n_wd_valid;
    logic [31:0]         n_wd_tag   [MAX_WAYS];
    logic [31:0]         n_wd_stamp [MAX_WAYS];
    logic [OUT_W-1:0]    n_outcome;
    logic                n_is_hit;
    logic                n_is_evict;

    // index of the set and tag
    always_comb begin
        n_block = i_address >> i_cfg_offset;
        for (int i = 0; i < SIW; i++) begin
            n_set_mask[i] = (int'(i_cfg_set_bits) > i) && (i < MAX_SET_BITS);
        end
    end

    // way compare
    always_comb begin
        n_hit_way = '0;
        n_inv_way = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            n_active[i] = (i == 0) || (i < int'(i_cfg_ways));
            n_hit[i]    = n_active[i] && r_q_valid[i] && (r_q_tag[i] == r_block);
            n_inv[i]    = n_active[i] && !r_q_valid[i];
        end
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (n_hit[i]) begin
                n_hit_way = WW'(i);
            end
            if (n_inv[i]) begin
                n_inv_way = WW'(i);
            end
        end
    end

    assign n_is_hit   = i_cmd.cmp_wr && (|n_hit);
    assign n_is_evict = i_cmd.vic_wr;
    assign n_load     = i_cmd.cmp_wr || i_cmd.vic_wr;
    assign n_wr       = i_cmd.clr || n_load;

    always_comb begin
        if (i_cmd.vic_wr) begin
            n_wsel = r_vic;
        end else if (|n_hit) begin
            n_wsel = n_hit_way;
        end else begin
            n_wsel = n_inv_way;
        end

        if (n_is_evict) begin
            n_outcome = OUTCOME_EVICT;
        end else if (n_is_hit) begin
            n_outcome = OUTCOME_HIT;
        end else begin
            n_outcome = OUTCOME_MISS;
        end

        n_waddr = i_cmd.clr ? r_clr_cnt : r_set;
        n_wd_clk = i_cmd.clr ? 32'd0 : (r_q_clk + 32'd1);
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (i_cmd.clr) begin
                n_wd_valid[i] = 1'b0;
                n_wd_tag[i]   = '0;
                n_wd_stamp[i] = '0;
            end else if (WW'(i) == n_wsel) begin
                n_wd_valid[i] = 1'b1;
                n_wd_tag[i]   = r_block;
                n_wd_stamp[i] = r_q_clk;
            end else begin
                n_wd_valid[i] = r_q_valid[i];
                n_wd_tag[i]   = r_q_tag[i];
                n_wd_stamp[i] = r_q_stamp[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem_clk[n_waddr]   <= n_wd_clk;
            r_mem_valid[n_waddr] <= n_wd_valid;
            r_mem_tag[n_waddr]   <= n_wd_tag;
            r_mem_stamp[n_waddr] <= n_wd_stamp;
        end
        if (i_cmd.rd) begin
            r_q_clk   <= r_mem_clk[r_set];
            r_q_valid <= r_mem_valid[r_set];
            r_q_tag   <= r_mem_tag[r_set];
            r_q_stamp <= r_mem_stamp[r_set];
        end
    end

    // access capture and lru scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_block <= n_block;
            r_set   <= n_block[SIW-1:0] & n_set_mask;
            r_extra <= (i_opcode == OP_MODIFY);
        end
        if (i_cmd.scan_init) begin
            r_vic       <= '0;
            r_vic_stamp <= r_q_stamp[0];
            r_way       <= WW'(1);
        end else if (i_cmd.scan_step) begin
            if (r_q_stamp[r_way] < r_vic_stamp) begin
                r_vic       <= r_way;
                r_vic_stamp <= r_q_stamp[r_way];
            end
            r_way <= r_way + WW'(1);
        end
        if (n_load) begin
            r_outcome   <= n_outcome;
            r_out_extra <= r_extra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + SIW'(1);
            end
            if (n_load) begin
                r_hits   <= r_hits + CNT_W'(n_is_hit) + CNT_W'(r_extra);
                r_misses <= r_misses + CNT_W'(!n_is_hit);
                r_evicts <= r_evicts + CNT_W'(n_is_evict);
            end
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.clr_last  = (r_clr_cnt == SIW'(SETS - 1));
        o_sts.req_fetch = (i_opcode == OP_FETCH);
        o_sts.hit_any   = |n_hit;
        o_sts.inv_any   = |n_inv;
        o_sts.scan_none = (MAX_WAYS == 1) || (int'(i_cfg_ways) <= 1);
        o_sts.scan_last = (int'(r_way) >= MAX_WAYS - 1)
                          || (int'(r_way) + 1 >= int'(i_cfg_ways));
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_outcome         = r_outcome;
    assign o_extra_hit       = r_out_extra;
    assign o_total_hits      = r_hits;
    assign o_total_misses    = r_misses;
    assign o_total_evictions = r_evicts;

endmodule

`default_nettype wire

// ===== hdl/slc_ctrl.sv =====
// ----------------------------------------------------------------------------
// slc_ctrl
// Controller: memory clear, access sequencing, lru scan and write back.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire slc_pkg::t_sts i_sts,
    output slc_pkg::t_cmd      o_cmd
);
    import slc_pkg::*;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_WB   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !i_sts.req_fetch) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                if (i_sts.hit_any || i_sts.inv_any) begin
                    if (i_sts.out_free) begin
                        o_cmd.cmp_wr = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = i_sts.scan_none ? ST_WB : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (i_sts.out_free) begin
                    o_cmd.vic_wr = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/set_associative_lru_cache_sim_top.sv =====
// ----------------------------------------------------------------------------
// set_associative_lru_cache_sim_top
// Hit, miss and eviction model of a set-associative cache with LRU replacement.
// ----------------------------------------------------------------------------
// After reset the block clears its set memory, one set row per cycle, through
// all 2**MAX_SET_BITS rows, and accepts no access meanwhile. A data access
// that hits or fills an empty way then passes through accept, set row read,
// and compare with write back; an eviction instead walks the stamps of the
// active ways one per cycle before write back. The single read/write port of
// the set row memory serializes accesses. Instruction fetches are accepted
// while idle and give no result. A finished result waits in the output register
// while the next access is accepted; write back stalls only if it is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module set_associative_lru_cache_sim_top #(
    parameter int MAX_SET_BITS = slc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = slc_pkg::DEF_MAX_WAYS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    slc_req_if.sink                         i_req,
    slc_rsp_if.source                       o_rsp,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [slc_pkg::PADR_W-1:0] paddr,
    input  wire logic [slc_pkg::PDAT_W-1:0] pwdata,
    output logic [slc_pkg::PDAT_W-1:0]      prdata,
    output logic                            pready
);
    import slc_pkg::*;

    logic [SIB_W-1:0]  r_cfg_set_bits;
    logic [WAYS_W-1:0] r_cfg_ways;
    logic [OFS_W-1:0]  r_cfg_offset;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_cfg_wr;

    // register file
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_set_bits <= '0;
            r_cfg_ways     <= WAYS_W'(1);
            r_cfg_offset   <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_SET_BITS:    r_cfg_set_bits <= pwdata[SIB_W-1:0];
                REG_WAYS:        r_cfg_ways     <= pwdata[WAYS_W-1:0];
                REG_OFFSET_BITS: r_cfg_offset   <= pwdata[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SET_BITS:    prdata = PDAT_W'(r_cfg_set_bits);
            REG_WAYS:        prdata = PDAT_W'(r_cfg_ways);
            REG_OFFSET_BITS: prdata = PDAT_W'(r_cfg_offset);
            default:         prdata = '0;
        endcase
    end

    assign i_req.ready = w_in_ready;

    slc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    slc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_set_bits    (r_cfg_set_bits),
        .i_cfg_ways        (r_cfg_ways),
        .i_cfg_offset      (r_cfg_offset),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_opcode          (i_req.opcode),
        .i_address         (i_req.address),
        .i_out_ready       (o_rsp.ready),
        .o_out_valid       (o_rsp.valid),
        .o_outcome         (o_rsp.outcome),
        .o_extra_hit       (o_rsp.extra_hit),
        .o_total_hits      (o_rsp.total_hits),
        .o_total_misses    (o_rsp.total_misses),
        .o_total_evictions (o_rsp.total_evictions)
    );

endmodule

`default_nettype wire

// ===== hdl/slc_checker.sv =====
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks of the cache model, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_req_valid,
    input wire logic                       i_req_ready,
    input wire logic [slc_pkg::OPC_W-1:0]  i_req_opcode,
    input wire logic                       i_rsp_valid,
    input wire logic                       i_rsp_ready,
    input wire logic [slc_pkg::OUT_W-1:0]  i_rsp_outcome,
    input wire logic                       i_rsp_extra_hit,
    input wire logic [slc_pkg::CNT_W-1:0]  i_rsp_total_hits,
    input wire logic [slc_pkg::CNT_W-1:0]  i_rsp_total_misses,
    input wire logic [slc_pkg::CNT_W-1:0]  i_rsp_total_evictions
);
    import slc_pkg::*;

    // memory clear holds off accesses right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_req_ready)
        else $error("access accepted during memory clear");

    // a data access keeps the block busy in the next cycle
    a_busy_after_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_opcode != OP_FETCH)) |=> !i_req_ready)
        else $error("access accepted while previous access in flight");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid
            && $stable(i_rsp_outcome) && $stable(i_rsp_extra_hit)
            && $stable(i_rsp_total_hits) && $stable(i_rsp_total_misses)
            && $stable(i_rsp_total_evictions)))
        else $error("stalled result changed");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((i_rsp_outcome == OUTCOME_MISS) || (i_rsp_outcome == OUTCOME_HIT)
            || (i_rsp_outcome == OUTCOME_EVICT)))
        else $error("undefined outcome code");

endmodule

bind set_associative_lru_cache_sim_top slc_checker u_slc_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_req_valid           (i_req.valid),
    .i_req_ready           (i_req.ready),
    .i_req_opcode          (i_req.opcode),
    .i_rsp_valid           (o_rsp.valid),
    .i_rsp_ready           (o_rsp.ready),
    .i_rsp_outcome         (o_rsp.outcome),
    .i_rsp_extra_hit       (o_rsp.extra_hit),
    .i_rsp_total_hits      (o_rsp.total_hits),
    .i_rsp_total_misses    (o_rsp.total_misses),
    .i_rsp_total_evictions (o_rsp.total_evictions)
);

`default_nettype wire
